// ===== rtl/at_response_watcher_macros.svh =====
// ----------------------------------------------------------------------------
// at_response_watcher_macros
// Assertion shorthands for the reply watcher checks.
// ----------------------------------------------------------------------------
`ifndef AT_RESPONSE_WATCHER_MACROS_SVH
`define AT_RESPONSE_WATCHER_MACROS_SVH

// clocked check, off while reset is asserted
`define ATRW_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// a stalled output request keeps its value
`define ATRW_ASSERT_HOLD(name, sig, msg) \
  `ATRW_ASSERT(name, out_valid_o && !out_ready_i |=> $stable(sig), msg)

`endif

// ===== rtl/atrw_pkg.sv =====
// ----------------------------------------------------------------------------
// atrw_pkg
// Types, codes and match words shared by the reply watcher.
// ----------------------------------------------------------------------------
package atrw_pkg;

  localparam int unsigned MaxReplyChars = 16;
  localparam int unsigned CfgWidth      = 64;
  localparam int unsigned ErrorLen      = 5;
  localparam int unsigned FailLen       = 4;

  typedef enum logic [1:0] {
    FuncStart  = 2'd0,
    FuncTick   = 2'd1,
    FuncByte   = 2'd2,
    FuncUnused = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    StWaiting = 3'd0,
    StMatched = 3'd1,
    StError   = 3'd2,
    StTimeout = 3'd3,
    StIdle    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    CfgExpectedLow    = 3'd0,
    CfgExpectedHigh   = 3'd1,
    CfgExpectedLength = 3'd2,
    CfgTimeoutTicks   = 3'd3,
    CfgWatchErrors    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [63:0] expected_low;
    logic [63:0] expected_high;
    logic [4:0]  expected_length;
    logic [19:0] timeout_ticks;
    logic        watch_errors;
  } cfg_t;

  typedef struct packed {
    func_e       func;
    logic [7:0]  byte_value;
  } item_t;

  function automatic logic [7:0] error_char(logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = "E";
      3'd1:    c = "R";
      3'd2:    c = "R";
      3'd3:    c = "O";
      3'd4:    c = "R";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] fail_char(logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = "F";
      3'd1:    c = "A";
      3'd2:    c = "I";
      3'd3:    c = "L";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/at_response_watcher.sv =====
// ----------------------------------------------------------------------------
// at_response_watcher
// Watches modem reply bytes for the expected reply, ERROR or FAIL, with timeout.
// ----------------------------------------------------------------------------
//  channel   handshake               payload
//  in        in_valid_i/in_ready_o   func_i, byte_value_i
//  out       out_valid_o/out_ready_i status_o
//  cfg       cfg_we_i                cfg_index_i, cfg_wdata_i
//
//  one request per cycle sustained while the result side takes each status
//  the input register feeds the match step, the result register holds its status
//  a stalled result does not block the input register, so one more request is taken
//  reset clears the match state (no wait active) and loads the default reply "OK"
// ----------------------------------------------------------------------------
module at_response_watcher #(
  parameter int unsigned MaxReplyChars = atrw_pkg::MaxReplyChars
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    func_i,
  input  logic [7:0]                    byte_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    status_o,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_index_i,
  input  logic [atrw_pkg::CfgWidth-1:0] cfg_wdata_i
);
  import atrw_pkg::*;

  cfg_t    cfg;
  item_t   stage_q;
  logic    stage_valid_q, stage_valid_d;
  logic    out_valid_q, out_valid_d;
  status_e status_q;
  status_e step_status;
  logic    advance;
  logic    in_accept;

  atrw_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  atrw_core #(
    .MaxReplyChars (MaxReplyChars)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .item_i   (stage_q),
    .step_i   (advance),
    .status_o (step_status)
  );

  // the staged request moves on when the result register is free or drains
  assign advance    = stage_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !stage_valid_q || advance;
  assign in_accept  = in_valid_i && in_ready_o;

  always_comb begin
    stage_valid_d = stage_valid_q;
    if (in_accept)    stage_valid_d = 1'b1;
    else if (advance) stage_valid_d = 1'b0;
    out_valid_d = out_valid_q;
    if (advance)          out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      stage_valid_q <= stage_valid_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      stage_q.func       <= func_e'(func_i);
      stage_q.byte_value <= byte_value_i;
    end
    if (advance) status_q <= step_status;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;

endmodule

// ===== rtl/atrw_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// atrw_cfg_regs
// Configuration register file, write only, with the power-up reply "OK".
// ----------------------------------------------------------------------------
module atrw_cfg_regs (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [2:0]             cfg_index_i,
  input  logic [63:0]            cfg_wdata_i,
  output atrw_pkg::cfg_t         cfg_o
);
  import atrw_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgExpectedLow:    cfg_d.expected_low    = cfg_wdata_i;
        CfgExpectedHigh:   cfg_d.expected_high   = cfg_wdata_i;
        CfgExpectedLength: cfg_d.expected_length = cfg_wdata_i[4:0];
        CfgTimeoutTicks:   cfg_d.timeout_ticks   = cfg_wdata_i[19:0];
        CfgWatchErrors:    cfg_d.watch_errors    = cfg_wdata_i[0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.expected_low    <= 64'h4B4F;
      cfg_q.expected_high   <= 64'h0;
      cfg_q.expected_length <= 5'd2;
      cfg_q.timeout_ticks   <= 20'd1000;
      cfg_q.watch_errors    <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/atrw_core.sv =====
// ----------------------------------------------------------------------------
// atrw_core
// Match positions, tick counter and the one-request step logic.
// ----------------------------------------------------------------------------
module atrw_core #(
  parameter int unsigned MaxReplyChars = atrw_pkg::MaxReplyChars
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  atrw_pkg::cfg_t         cfg_i,
  input  atrw_pkg::item_t        item_i,
  input  logic                   step_i,
  output atrw_pkg::status_e      status_o
);
  import atrw_pkg::*;

  localparam logic [4:0] MaxLen = 5'(MaxReplyChars);

  logic [4:0]  reply_pos_q, reply_pos_d;
  logic [2:0]  error_pos_q, error_pos_d;
  logic [2:0]  fail_pos_q, fail_pos_d;
  logic [19:0] ticks_q, ticks_d;
  logic        waiting_q, waiting_d;

  logic [4:0]  reply_len;
  logic [63:0] reply_word;
  logic [7:0]  reply_ch;
  logic        reply_hit;
  logic        error_hit;
  logic        fail_hit;
  status_e     st;

  always_comb begin
    reply_len = cfg_i.expected_length;
    if (reply_len == 5'd0) reply_len = 5'd1;
    if (reply_len > MaxLen) reply_len = MaxLen;
  end

  // character under the reply position, low word holds characters 0 to 7
  assign reply_word = reply_pos_q[3] ? cfg_i.expected_high : cfg_i.expected_low;
  assign reply_ch   = reply_word[{reply_pos_q[2:0], 3'b000} +: 8];

  assign reply_hit = (reply_pos_q < reply_len) && (item_i.byte_value == reply_ch);
  assign error_hit = (error_pos_q < 3'(ErrorLen))
                     && (item_i.byte_value == error_char(error_pos_q));
  assign fail_hit  = (fail_pos_q < 3'(FailLen))
                     && (item_i.byte_value == fail_char(fail_pos_q));

  always_comb begin
    reply_pos_d = reply_pos_q;
    error_pos_d = error_pos_q;
    fail_pos_d  = fail_pos_q;
    ticks_d     = ticks_q;
    waiting_d   = waiting_q;
    st          = StWaiting;
    if (item_i.func == FuncStart) begin
      reply_pos_d = '0;
      error_pos_d = '0;
      fail_pos_d  = '0;
      ticks_d     = '0;
      waiting_d   = 1'b1;
    end else if (item_i.func == FuncUnused || !waiting_q) begin
      st = waiting_q ? StWaiting : StIdle;
    end else if (ticks_q >= cfg_i.timeout_ticks) begin
      st        = StTimeout;
      waiting_d = 1'b0;
    end else begin
      if (item_i.func == FuncByte) begin
        if (reply_hit) begin
          if ((reply_pos_q + 5'd1) >= reply_len) begin
            reply_pos_d = '0;
            st          = StMatched;
          end else begin
            reply_pos_d = reply_pos_q + 5'd1;
          end
        end else begin
          reply_pos_d = '0;
        end
        // error words only run while the reply has not completed
        if (st == StWaiting && cfg_i.watch_errors) begin
          if (error_hit) begin
            if ((error_pos_q + 3'd1) >= 3'(ErrorLen)) begin
              error_pos_d = '0;
              st          = StError;
            end else begin
              error_pos_d = error_pos_q + 3'd1;
            end
          end else begin
            error_pos_d = '0;
          end
          if (st == StWaiting) begin
            if (fail_hit) begin
              if ((fail_pos_q + 3'd1) >= 3'(FailLen)) begin
                fail_pos_d = '0;
                st         = StError;
              end else begin
                fail_pos_d = fail_pos_q + 3'd1;
              end
            end else begin
              fail_pos_d = '0;
            end
          end
        end
      end
      if (st == StWaiting) begin
        ticks_d = ticks_q + 20'd1;
        if (ticks_d >= cfg_i.timeout_ticks) st = StTimeout;
      end
      if (st != StWaiting) waiting_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reply_pos_q <= '0;
      error_pos_q <= '0;
      fail_pos_q  <= '0;
      ticks_q     <= '0;
      waiting_q   <= 1'b0;
    end else if (step_i) begin
      reply_pos_q <= reply_pos_d;
      error_pos_q <= error_pos_d;
      fail_pos_q  <= fail_pos_d;
      ticks_q     <= ticks_d;
      waiting_q   <= waiting_d;
    end
  end

  assign status_o = st;

endmodule

// ===== rtl/atrw_checker.sv =====
// ----------------------------------------------------------------------------
// atrw_checker
// Port-level checks on the reply watcher, bound to the top level.
// ----------------------------------------------------------------------------
`include "at_response_watcher_macros.svh"

module atrw_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] status_o
);

  // with no result pending the input register always drains
  `ATRW_ASSERT(a_ready_when_empty, !out_valid_o |-> in_ready_o, "input stalled with empty output")

  // every accepted request is followed by a valid result on the output
  `ATRW_ASSERT(a_result_follows, in_valid_i && in_ready_o |-> ##2 out_valid_o, "request lost")

  `ATRW_ASSERT(a_valid_holds, out_valid_o && !out_ready_i |=> out_valid_o, "result dropped")

  `ATRW_ASSERT_HOLD(a_status_holds, status_o, "status changed while stalled")

endmodule

bind at_response_watcher atrw_checker u_atrw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .status_o    (status_o)
);

// ===== tb/sv/at_response_watcher_test.sv =====
// ----------------------------------------------------------------------------
// at_response_watcher_test
// Drives start, tick, byte and unused requests into the reply watcher under changing
// reply, timeout and error-watch settings, predicts every status and compares
// each returned status with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module at_response_watcher_test;
  import atrw_pkg::*;

  localparam int unsigned PhaseCount  = 12;
  localparam int unsigned PhaseItems  = 94;
  localparam int unsigned HoldCycles  = 300;
  localparam logic [2:0]  UnusedCfgIdx = 3'd7;
  localparam logic [8*ErrorLen-1:0] ErrWord  = "ERROR";
  localparam logic [8*FailLen-1:0]  FailWord = "FAIL";

  typedef enum {AimReply, AimError, AimFail, AimNoise} aim_e;

  typedef struct {
    bit          is_cfg;
    logic [2:0]  cfg_idx;
    logic [63:0] cfg_val;
    func_e       func;
    logic [7:0]  byte_val;
    bit          pinned;
    status_e     status;
  } dir_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [1:0]          func_i;
  logic [7:0]          byte_value_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [2:0]          status_o;
  logic                cfg_we_i;
  logic [2:0]          cfg_index_i;
  logic [CfgWidth-1:0] cfg_wdata_i;

  // register copy
  logic [63:0] exp_low;
  logic [63:0] exp_high;
  logic [4:0]  exp_len;
  logic [19:0] tmo_ticks;
  logic        watch_err;

  // match state copy
  logic [4:0]  reply_pos;
  logic [2:0]  err_pos;
  logic [2:0]  fail_pos;
  logic [19:0] tick_count;
  logic        wait_active;

  status_e     pending_status[$];
  dir_row_t    dir_rows[$];
  int unsigned mismatch_count;
  int unsigned in_idle_pct;
  int unsigned out_idle_pct;
  int unsigned hold_req_count;
  bit          pin_valid;
  status_e     pin_status;
  aim_e        aim;

  at_response_watcher dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .byte_value_i (byte_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3000000;
    $display("simulation failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic logic [4:0] reply_len();
    if (exp_len == 5'd0) return 5'd1;
    if (exp_len > 5'(MaxReplyChars)) return 5'(MaxReplyChars);
    return exp_len;
  endfunction

  function automatic logic [7:0] reply_char(input logic [4:0] pos);
    logic [63:0] w;
    w = pos[3] ? exp_high : exp_low;
    return w[pos[2:0]*8 +: 8];
  endfunction

  function automatic logic [7:0] err_char(input logic [2:0] pos);
    if (pos >= ErrorLen) return 8'h00;
    return ErrWord[8*(ErrorLen-1-pos) +: 8];
  endfunction

  function automatic logic [7:0] fail_letter(input logic [2:0] pos);
    if (pos >= FailLen) return 8'h00;
    return FailWord[8*(FailLen-1-pos) +: 8];
  endfunction

  // steps one word matcher, true when the word completes
  function automatic bit word_hit(inout logic [2:0] pos, input logic [7:0] ch,
                                  input logic [7:0] want, input int unsigned len);
    if (pos < len && ch == want) begin
      pos = pos + 3'd1;
      if (pos >= len) begin
        pos = 3'd0;
        return 1'b1;
      end
    end else begin
      pos = 3'd0;
    end
    return 1'b0;
  endfunction

  function automatic status_e predict_status(input func_e f, input logic [7:0] ch);
    status_e st;
    logic [2:0] p;
    if (f == FuncStart) begin
      reply_pos   = '0;
      err_pos     = '0;
      fail_pos    = '0;
      tick_count  = '0;
      wait_active = 1'b1;
      st = StWaiting;
    end else if (f == FuncUnused || !wait_active) begin
      st = wait_active ? StWaiting : StIdle;
    end else if (tick_count >= tmo_ticks) begin
      wait_active = 1'b0;
      st = StTimeout;
    end else begin
      st = StWaiting;
      if (f == FuncByte) begin
        if (reply_pos < reply_len() && ch == reply_char(reply_pos)) begin
          reply_pos = reply_pos + 5'd1;
          if (reply_pos >= reply_len()) begin
            reply_pos   = '0;
            wait_active = 1'b0;
            st = StMatched;
          end
        end else begin
          reply_pos = '0;
        end
        if (st == StWaiting && watch_err) begin
          p = err_pos;
          if (word_hit(p, ch, err_char(err_pos), ErrorLen)) begin
            err_pos = p;
            wait_active = 1'b0;
            st = StError;
          end else begin
            err_pos = p;
            p = fail_pos;
            if (word_hit(p, ch, fail_letter(fail_pos), FailLen)) begin
              wait_active = 1'b0;
              st = StError;
            end
            fail_pos = p;
          end
        end
      end
      if (st == StWaiting) begin
        tick_count = tick_count + 20'd1;
        if (tick_count >= tmo_ticks) begin
          wait_active = 1'b0;
          st = StTimeout;
        end
      end
    end
    return st;
  endfunction

  // scoreboard: check returned status first, then predict the accepted request
  always @(posedge clk_i) begin
    status_e want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_status.size() == 0) begin
          report_mismatch($sformatf("status %0d with nothing pending", status_o));
        end else begin
          want = pending_status.pop_front();
          if (status_o !== want)
            report_mismatch($sformatf("status got %0d expected %0d", status_o, want));
        end
      end
      if (in_valid_i && in_ready_o) begin
        want = predict_status(func_e'(func_i), byte_value_i);
        if (pin_valid) want = pin_status;
        pending_status.push_back(want);
      end
    end
  end

  // result side: random stalls plus long hold-offs on request
  initial begin
    int unsigned hold_seen;
    int unsigned hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_seen != hold_req_count) begin
        hold_seen = hold_req_count;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_req(input func_e f, input logic [7:0] b);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    func_i       <= f;
    byte_value_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // wait for every pending status, then let the pipeline empty
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_status.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CfgExpectedLow:    exp_low   = val;
      CfgExpectedHigh:   exp_high  = val;
      CfgExpectedLength: exp_len   = val[4:0];
      CfgTimeoutTicks:   tmo_ticks = val[19:0];
      CfgWatchErrors:    watch_err = val[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic add_item(input func_e f, input logic [7:0] b, input bit pinned,
                          input status_e st);
    dir_row_t row;
    row.is_cfg   = 1'b0;
    row.cfg_idx  = '0;
    row.cfg_val  = '0;
    row.func     = f;
    row.byte_val = b;
    row.pinned   = pinned;
    row.status   = st;
    dir_rows.push_back(row);
  endtask

  task automatic add_cfg(input logic [2:0] idx, input logic [63:0] val);
    dir_row_t row;
    row.is_cfg   = 1'b1;
    row.cfg_idx  = idx;
    row.cfg_val  = val;
    row.func     = FuncTick;
    row.byte_val = '0;
    row.pinned   = 1'b0;
    row.status   = StWaiting;
    dir_rows.push_back(row);
  endtask

  function automatic logic [19:0] pick_timeout();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) return 20'($urandom_range(3));
    if (r < 80) return 20'($urandom_range(64, 2));
    return 20'($urandom);
  endfunction

  task automatic setup_phase(input int unsigned p);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0]  len;
    logic [19:0] tmo;
    logic        we;
    lo  = {$urandom, $urandom};
    hi  = {$urandom, $urandom};
    len = ($urandom_range(99) < 70) ? 5'($urandom_range(5, 1)) : 5'($urandom_range(31));
    tmo = pick_timeout();
    we  = 1'($urandom_range(1));
    case (p)
      0: begin len = 5'($urandom_range(4, 1)); tmo = 20'($urandom_range(40, 8)); we = 1'b1; end
      1: begin len = 5'd16; tmo = 20'hFFFFF; we = 1'b1; end
      2: begin len = 5'd0; tmo = 20'd0; we = 1'b1; end
      3: begin lo = '1; hi = '1; len = 5'd31; tmo = 20'd1; we = 1'b1; end
      4: begin lo = '0; hi = '0; len = 5'd3; tmo = 20'($urandom_range(30, 10)); we = 1'b0; end
      5: begin len = 5'd17; tmo = 20'($urandom_range(200, 20)); we = 1'b0; end
      6: write_reg(UnusedCfgIdx, {$urandom, $urandom});
      default: ;
    endcase
    write_reg(CfgExpectedLow, lo);
    write_reg(CfgExpectedHigh, hi);
    write_reg(CfgExpectedLength, {59'd0, len});
    write_reg(CfgTimeoutTicks, {44'd0, tmo});
    write_reg(CfgWatchErrors, {63'd0, we});
  endtask

  // mostly well-formed replies or error words with ticks in between, some noise
  task automatic next_item(output func_e f, output logic [7:0] b);
    int unsigned r;
    int unsigned c;
    r = $urandom_range(99);
    b = 8'($urandom);
    if (!wait_active) begin
      f = (r < 85) ? FuncStart : (r < 92) ? FuncUnused : (r < 96) ? FuncTick : FuncByte;
    end else begin
      f = (r < 4) ? FuncStart : (r < 7) ? FuncUnused : (r < 25) ? FuncTick : FuncByte;
    end
    if (f == FuncStart) begin
      c = $urandom_range(99);
      aim = (c < 65) ? AimReply : (c < 77) ? AimError : (c < 89) ? AimFail : AimNoise;
    end else if (f == FuncByte && $urandom_range(99) >= 6) begin
      case (aim)
        AimReply: b = reply_char(reply_pos);
        AimError: b = err_char(err_pos);
        AimFail:  b = fail_letter(fail_pos);
        default:  ;
      endcase
    end
  endtask

  initial begin
    func_e       f;
    logic [7:0]  b;
    int unsigned sent;
    int unsigned waited;
    bit          paused;
    in_valid_i     = 1'b0;
    func_i         = FuncStart;
    byte_value_i   = '0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = '0;
    cfg_wdata_i    = '0;
    mismatch_count = 0;
    hold_req_count = 0;
    pin_valid      = 1'b0;
    pin_status     = StWaiting;
    aim            = AimReply;
    in_idle_pct    = 20;
    out_idle_pct   = 69;
    exp_low        = 64'h4B4F;
    exp_high       = '0;
    exp_len        = 5'd2;
    tmo_ticks      = 20'd1000;
    watch_err      = 1'b1;
    reply_pos      = '0;
    err_pos        = '0;
    fail_pos       = '0;
    tick_count     = '0;
    wait_active    = 1'b0;

    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // defaults after reset: reply "OK", errors watched
    add_item(FuncTick,   8'h00, 1, StIdle);
    add_item(FuncUnused, 8'h00, 1, StIdle);
    add_item(FuncByte,   8'hFF, 1, StIdle);
    add_item(FuncStart,  8'h00, 1, StWaiting);
    add_item(FuncUnused, 8'hFF, 1, StWaiting);
    add_item(FuncByte,   "O",   0, StWaiting);
    add_item(FuncByte,   "K",   1, StMatched);
    add_item(FuncStart,  8'h00, 1, StWaiting);
    add_item(FuncByte,   "E",   0, StWaiting);
    add_item(FuncByte,   "R",   0, StWaiting);
    add_item(FuncByte,   "R",   0, StWaiting);
    add_item(FuncByte,   "O",   0, StWaiting);
    add_item(FuncByte,   "R",   1, StError);
    add_item(FuncStart,  8'h00, 1, StWaiting);
    add_item(FuncByte,   "F",   0, StWaiting);
    add_item(FuncByte,   "A",   0, StWaiting);
    add_item(FuncByte,   "I",   0, StWaiting);
    add_item(FuncByte,   "L",   1, StError);
    // error watch switched off mid wait, positions must hold
    add_item(FuncStart,  8'h00, 1, StWaiting);
    add_item(FuncByte,   "E",   0, StWaiting);
    add_item(FuncByte,   "R",   0, StWaiting);
    add_cfg(CfgWatchErrors, 64'd0);
    add_item(FuncTick,   8'h00, 0, StWaiting);
    add_item(FuncTick,   8'h00, 0, StWaiting);
    add_cfg(CfgWatchErrors, 64'd1);
    add_item(FuncByte,   "R",   0, StWaiting);
    add_item(FuncByte,   "O",   0, StWaiting);
    add_item(FuncByte,   "R",   1, StError);
    // zero timeout: the first byte request after start ends the wait
    add_cfg(CfgTimeoutTicks, 64'd0);
    add_item(FuncStart,  8'h00, 1, StWaiting);
    add_item(FuncByte,   "O",   1, StTimeout);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        settle();
        write_reg(dir_rows[i].cfg_idx, dir_rows[i].cfg_val);
      end else begin
        pin_valid  = dir_rows[i].pinned;
        pin_status = dir_rows[i].status;
        send_req(dir_rows[i].func, dir_rows[i].byte_val);
      end
    end
    settle();
    pin_valid = 1'b0;

    for (int unsigned p = 0; p < PhaseCount; p++) begin
      if (p < 4) begin
        in_idle_pct  = 20;
        out_idle_pct = 69;
      end else if (p < 8) begin
        in_idle_pct  = 69;
        out_idle_pct = 20;
      end else begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      setup_phase(p);
      // long result stall while requests keep coming
      if (p == 1 || p == 9) hold_req_count++;
      sent   = 0;
      paused = 1'b0;
      while (sent < PhaseItems) begin
        next_item(f, b);
        if (wait_active || f == FuncStart) sent++;
        send_req(f, b);
        if (p == 5 && !paused && sent >= PhaseItems / 2) begin
          paused = 1'b1;
          settle();
        end
      end
      settle();
    end

    in_valid_i <= 1'b0;
    waited = 0;
    while (pending_status.size() != 0 && waited < 5000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (10) @(negedge clk_i);
    if (pending_status.size() != 0)
      report_mismatch($sformatf("%0d statuses never returned", pending_status.size()));
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/atrw_pkg.sv
rtl/atrw_cfg_regs.sv
rtl/atrw_core.sv
rtl/at_response_watcher.sv
rtl/atrw_checker.sv
tb/sv/at_response_watcher_test.sv
